// File: hdl/bwts_pkg.sv
// Shared types, widths and helper functions of the bilinear wrap texture sampler.
// No dependencies.
package bwts_pkg;

  localparam int CH_W        = 16;
  localparam int TEXEL_W     = 3 * CH_W;
  localparam int COORD_W     = 24;
  localparam int SIZE_W      = 9;
  localparam int POS_W       = 8;
  localparam int ADDR_W      = 16;
  localparam int TEXEL_COUNT = 1 << ADDR_W;
  localparam int FRAC_W      = 16;
  localparam int MAG_W       = 16;
  localparam int GRAD_W      = 17;
  localparam int MAX_SIDE    = 256;
  localparam int HALF_TEXEL  = 32768;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_GRAD   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_SIDE)) begin
      r = SIZE_W'(MAX_SIDE);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] tex_addr(input logic [POS_W-1:0] row,
                                                 input logic [POS_W-1:0] col,
                                                 input logic [SIZE_W-1:0] w);
    logic [POS_W+SIZE_W:0] a;
    a = (POS_W + SIZE_W + 1)'(row) * (POS_W + SIZE_W + 1)'(w) + (POS_W + SIZE_W + 1)'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/bilinear_wrap_texture_sampler.sv
// Top level: config registers, texel store copies and the filter pipeline.
// Uses bwts_pkg and bwts_axis.
//
//  channel | ports                                   | flow
//  in      | in_valid_i / in_stall_o, op + payload   | write, sample, gradient
//  out     | out_valid_o / out_stall_i, colors, grad | one transfer per sample/gradient
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i       | register write, no wait
//
// An item enters every cycle unless the output stalls; it passes through the axis stages,
// then address, store read and blend, to the output register.
// Four copies of the texel store give the four neighbour reads in the same cycle.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears valid bits and sets config to its defaults only; the store needs no clearing.
module bilinear_wrap_texture_sampler import bwts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                opcode_i,
  input  logic [ADDR_W-1:0]         texel_index_i,
  input  logic [CH_W-1:0]           in_red_i,
  input  logic [CH_W-1:0]           in_green_i,
  input  logic [CH_W-1:0]           in_blue_i,
  input  logic signed [COORD_W-1:0] coord_u_i,
  input  logic signed [COORD_W-1:0] coord_v_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [CH_W-1:0]           out_red_o,
  output logic [CH_W-1:0]           out_green_o,
  output logic [CH_W-1:0]           out_blue_o,
  output logic signed [GRAD_W-1:0]  grad_x_o,
  output logic signed [GRAD_W-1:0]  grad_y_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AXIS_LAT = 6;
  localparam int LAST     = 10;

  logic              color_mode_q;
  logic [SIZE_W-1:0] tex_width_q;
  logic [SIZE_W-1:0] tex_height_q;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  logic              en;
  logic [LAST:1]     vld_q;
  op_e               op_q    [1:9];
  logic [ADDR_W-1:0] idx_q   [1:AXIS_LAT+1];
  logic [TEXEL_W-1:0] rgb_q  [1:AXIS_LAT+1];

  axis_t             ax_u;
  axis_t             ax_v;

  logic [ADDR_W-1:0] addr_q  [4];
  logic [FRAC_W-1:0] fu_q7, fu_q8;
  logic [FRAC_W-1:0] fv_q7, fv_q8, fv_q9;
  logic [TEXEL_W-1:0] rd_q   [4];

  logic [2*CH_W-1:0] bot_q9  [3];
  logic [2*CH_W-1:0] top_q9  [3];
  logic [2*CH_W-1:0] bot_q10 [3];
  logic signed [2*CH_W+FRAC_W+1:0] prod_q10 [3];
  logic [CH_W-1:0]   res     [3];
  logic signed [GRAD_W-1:0] gx_q9, gy_q9, gx_q10, gy_q10;
  logic              grad_q10;

  logic              out_valid_q;
  logic              out_grad_q;
  logic [CH_W-1:0]   out_red_q, out_green_q, out_blue_q;
  logic signed [GRAD_W-1:0] grad_x_q, grad_y_q;

  assign w_eff = eff_size(tex_width_q);
  assign h_eff = eff_size(tex_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b1;
      tex_width_q  <= SIZE_W'(MAX_SIDE);
      tex_height_q <= SIZE_W'(MAX_SIDE);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLOR_MODE: color_mode_q <= cfg_data_i[0];
        CFG_TEX_WIDTH:  tex_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_TEX_HEIGHT: tex_height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q[1] <= in_valid_i && (op_e'(opcode_i) != OP_NONE);
      for (int k = 2; k <= 8; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      vld_q[9]  <= vld_q[8] && (op_q[8] != OP_WRITE);
      vld_q[10] <= vld_q[9];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[1]  <= op_e'(opcode_i);
      idx_q[1] <= texel_index_i;
      rgb_q[1] <= {in_blue_i, in_green_i, in_red_i};
      for (int k = 2; k <= 9; k++) begin
        op_q[k] <= op_q[k-1];
      end
      for (int k = 2; k <= AXIS_LAT + 1; k++) begin
        idx_q[k] <= idx_q[k-1];
        rgb_q[k] <= rgb_q[k-1];
      end
    end
  end

  bwts_axis u_axis_u (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (coord_u_i),
    .size_i  (w_eff),
    .res_o   (ax_u)
  );

  bwts_axis u_axis_v (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (coord_v_i),
    .size_i  (h_eff),
    .res_o   (ax_v)
  );

  // neighbour order: left-bottom, right-bottom, left-top, right-top
  always_ff @(posedge clk_i) begin
    if (en) begin
      addr_q[0] <= tex_addr(ax_v.lo, ax_u.lo, w_eff);
      addr_q[1] <= tex_addr(ax_v.lo, ax_u.hi, w_eff);
      addr_q[2] <= tex_addr(ax_v.hi, ax_u.lo, w_eff);
      addr_q[3] <= tex_addr(ax_v.hi, ax_u.hi, w_eff);
      fu_q7     <= ax_u.frac;
      fv_q7     <= ax_v.frac;
      fu_q8     <= fu_q7;
      fv_q8     <= fv_q7;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_mem
    logic [TEXEL_W-1:0] tex_mem [TEXEL_COUNT];
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vld_q[AXIS_LAT+1] && op_q[AXIS_LAT+1] == OP_WRITE) begin
          tex_mem[idx_q[AXIS_LAT+1]] <= rgb_q[AXIS_LAT+1];
        end
        rd_q[j] <= tex_mem[addr_q[j]];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic signed [CH_W:0]       dh_b, dh_t;
    logic signed [2*CH_W+1:0]   ph_b, ph_t, sum_b, sum_t;
    logic signed [2*CH_W:0]     dv;
    logic signed [2*CH_W+FRAC_W+2:0] acc;

    always_comb begin
      dh_b  = $signed({1'b0, rd_q[1][CH_W*c +: CH_W]}) - $signed({1'b0, rd_q[0][CH_W*c +: CH_W]});
      dh_t  = $signed({1'b0, rd_q[3][CH_W*c +: CH_W]}) - $signed({1'b0, rd_q[2][CH_W*c +: CH_W]});
      ph_b  = dh_b * $signed({1'b0, fu_q8});
      ph_t  = dh_t * $signed({1'b0, fu_q8});
      sum_b = $signed({2'b00, rd_q[0][CH_W*c +: CH_W], {FRAC_W{1'b0}}}) + ph_b;
      sum_t = $signed({2'b00, rd_q[2][CH_W*c +: CH_W], {FRAC_W{1'b0}}}) + ph_t;
      dv    = $signed({1'b0, top_q9[c]}) - $signed({1'b0, bot_q9[c]});
      acc   = $signed({3'b000, bot_q10[c], {FRAC_W{1'b0}}})
            + $signed({prod_q10[c][2*CH_W+FRAC_W+1], prod_q10[c]})
            + $signed((2*CH_W+FRAC_W+3)'(64'd1 << 31));
      res[c] = acc[2*CH_W+FRAC_W-1 -: CH_W];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        bot_q9[c]   <= sum_b[2*CH_W-1:0];
        top_q9[c]   <= sum_t[2*CH_W-1:0];
        bot_q10[c]  <= bot_q9[c];
        prod_q10[c] <= dv * $signed({1'b0, fv_q9});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q9    <= $signed({1'b0, rd_q[1][CH_W-1:0]}) - $signed({1'b0, rd_q[0][CH_W-1:0]});
      gy_q9    <= $signed({1'b0, rd_q[2][CH_W-1:0]}) - $signed({1'b0, rd_q[0][CH_W-1:0]});
      fv_q9    <= fv_q8;
      gx_q10   <= gx_q9;
      gy_q10   <= gy_q9;
      grad_q10 <= (op_q[9] == OP_GRAD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_grad_q <= grad_q10;
      if (grad_q10) begin
        out_red_q   <= '0;
        out_green_q <= '0;
        out_blue_q  <= '0;
        grad_x_q    <= gx_q10;
        grad_y_q    <= gy_q10;
      end else begin
        out_red_q   <= res[0];
        out_green_q <= color_mode_q ? res[1] : res[0];
        out_blue_q  <= color_mode_q ? res[2] : res[0];
        grad_x_q    <= '0;
        grad_y_q    <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign grad_x_o    = grad_x_q;
  assign grad_y_o    = grad_y_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_no_late_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[9] |-> op_q[9] != OP_WRITE)
    else $error("write item past store stage");

  a_grad_colors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_grad_q) |-> (out_red_q == '0 && out_green_q == '0 && out_blue_q == '0))
    else $error("gradient transfer with color data");

  a_sample_grads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_grad_q) |-> (grad_x_q == '0 && grad_y_q == '0))
    else $error("sample transfer with gradient data");

endmodule

// File: hdl/bwts_axis.sv
// One coordinate axis: scale, half-texel offset, floor and wrap modulo size.
// Six register stages; the remainder runs four bits per stage. Uses bwts_pkg.
module bwts_axis import bwts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] coord_i,
  input  logic [SIZE_W-1:0]         size_i,
  output axis_t                     res_o
);

  localparam int REM_STAGES = 4;
  localparam int BITS_PER   = MAG_W / REM_STAGES;

  function automatic logic [POS_W-1:0] rem_step(input logic [POS_W-1:0] rem,
                                                input logic [BITS_PER-1:0] bits,
                                                input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] t;
    logic [POS_W-1:0]  r;
    r = rem;
    for (int i = BITS_PER - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= size) begin
        t = t - size;
      end
      r = t[POS_W-1:0];
    end
    return r;
  endfunction

  logic signed [COORD_W+SIZE_W+1:0] scaled;
  logic signed [COORD_W+SIZE_W-FRAC_W+1:0] fl;

  logic              neg_q  [REM_STAGES+1];
  logic [MAG_W-1:0]  mag_q  [REM_STAGES+1];
  logic [FRAC_W-1:0] frac_q [REM_STAGES+1];
  logic [POS_W-1:0]  rem_q  [REM_STAGES+1];
  axis_t             res_q;

  logic [POS_W-1:0]  lo_d;
  logic [SIZE_W-1:0] nxt;

  assign scaled = $signed({{(SIZE_W+2){coord_i[COORD_W-1]}}, coord_i})
                * $signed({{(COORD_W+2){1'b0}}, size_i})
                - $signed((COORD_W+SIZE_W+2)'(HALF_TEXEL));
  assign fl = scaled[COORD_W+SIZE_W+1:FRAC_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= fl[$bits(fl)-1];
      mag_q[0]  <= fl[$bits(fl)-1] ? ~fl[MAG_W-1:0] : fl[MAG_W-1:0];
      frac_q[0] <= scaled[FRAC_W-1:0];
      rem_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= REM_STAGES; k++) begin : g_rem
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k]  <= neg_q[k-1];
        mag_q[k]  <= mag_q[k-1];
        frac_q[k] <= frac_q[k-1];
        rem_q[k]  <= rem_step(rem_q[k-1],
                              mag_q[k-1][MAG_W-1-BITS_PER*(k-1) -: BITS_PER], size_i);
      end
    end
  end

  always_comb begin
    lo_d = neg_q[REM_STAGES]
         ? POS_W'(size_i - SIZE_W'(rem_q[REM_STAGES]) - SIZE_W'(1))
         : rem_q[REM_STAGES];
    nxt  = SIZE_W'(lo_d) + SIZE_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.lo   <= lo_d;
      res_q.hi   <= (nxt == size_i) ? '0 : nxt[POS_W-1:0];
      res_q.frac <= frac_q[REM_STAGES];
    end
  end

  assign res_o = res_q;

endmodule
